/* rtl/mdsg_pkg.sv */
// ============================================================================
// mdsg_pkg
// Shared types and constants for the motor drive stall guard.
// ============================================================================
package mdsg_pkg;

    // Command codes carried by the cmd field.
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_MODE   = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_DRIVE  = 2'd3
    } cmd_t;

    // Drive modes.
    typedef enum logic [2:0] {
        MODE_HOLD  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_POS   = 3'd2,
        MODE_DOWN  = 3'd3,
        MODE_VSTOP = 3'd4
    } mode_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_HOLD_VALUE    = 1'b0,
        CFG_CURRENT_LIMIT = 1'b1
    } cfg_idx_t;

    localparam int CfgDataWidth = 12;

    localparam logic [4:0]         HoldValueReset    = 5'd0;
    localparam logic [11:0]        CurrentLimitReset = 12'd2300;
    localparam logic [7:0]         StallSteps        = 8'd30;
    localparam logic [7:0]         StallCountMax     = 8'd255;
    localparam logic signed [7:0]  DriveMax          = 8'sd127;
    localparam logic signed [7:0]  DriveMin          = -8'sd127;

    // Hold direction, two bits two's complement.
    localparam logic signed [1:0]  DirNone = 2'sb00;
    localparam logic signed [1:0]  DirUp   = 2'sb01;
    localparam logic signed [1:0]  DirDown = 2'sb11;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               button_up;
        logic               button_down;
        logic signed [31:0] value;
        logic [11:0]        current_ma;
        logic signed [31:0] position;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              velocity_stop;
        logic              safe_mode;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         stall_count;
        logic               safe_flag;
        logic signed [1:0]  hold_direction;
        mode_t              mode_code;
        logic signed [31:0] target_position;
    } guard_state_t;

    typedef struct packed {
        logic [4:0]  hold_value;
        logic [11:0] current_limit;
    } guard_cfg_t;

endpackage

/* rtl/mdsg_step.sv */
// ============================================================================
// mdsg_step
// Combinational step: computes the result and next state for one command.
// ============================================================================
module mdsg_step
    import mdsg_pkg::*;
(
    input  in_item_t     item,
    input  guard_state_t state,
    input  guard_cfg_t   cfg,
    output logic         has_result,
    output out_item_t    result,
    output guard_state_t state_next
);

    function automatic logic signed [7:0] clamp_drive(input logic signed [32:0] v);
        logic signed [7:0] r;
        if (v > 33'sd127) begin
            r = DriveMax;
        end else if (v < -33'sd127) begin
            r = DriveMin;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic signed [7:0]  hold_drive;
    logic signed [32:0] pos_diff;
    logic signed [7:0]  request;
    logic               use_drive;
    logic [7:0]         magnitude;
    logic               stalled;
    logic [7:0]         count_inc;
    logic               safe_new;
    guard_state_t       state_base;

    always_comb begin
        if (state.hold_direction == DirUp) begin
            hold_drive = {3'b000, cfg.hold_value};
        end else if (state.hold_direction == DirDown) begin
            hold_drive = -$signed({3'b000, cfg.hold_value});
        end else begin
            hold_drive = 8'sd0;
        end
    end

    assign pos_diff = {state.target_position[31], state.target_position}
                    - {item.position[31], item.position};

    always_comb begin
        state_base = state;
        has_result = 1'b0;
        use_drive  = 1'b0;
        request    = 8'sd0;

        unique case (cmd_t'(item.cmd))
            CMD_MODE: begin
                if (item.value == 32'sd1) begin
                    state_base.mode_code = MODE_UP;
                end else if (item.value == -32'sd1) begin
                    state_base.mode_code = MODE_DOWN;
                end else if (item.value == 32'sd0) begin
                    state_base.mode_code = MODE_HOLD;
                end else if (item.value == 32'sd2) begin
                    state_base.mode_code = MODE_POS;
                end else begin
                    state_base.mode_code = MODE_VSTOP;
                end
            end
            CMD_TARGET: begin
                state_base.mode_code       = MODE_POS;
                state_base.target_position = item.value;
            end
            CMD_DRIVE: begin
                has_result = 1'b1;
                use_drive  = 1'b1;
                request    = clamp_drive({item.value[31], item.value});
            end
            CMD_TICK: begin
                has_result = 1'b1;
                use_drive  = 1'b1;
                priority if (item.button_up) begin
                    request                   = DriveMax;
                    state_base.mode_code      = MODE_HOLD;
                    state_base.hold_direction = DirUp;
                end else if (item.button_down) begin
                    request                   = DriveMin;
                    state_base.mode_code      = MODE_HOLD;
                    state_base.hold_direction = DirDown;
                end else begin
                    unique case (state.mode_code)
                        MODE_UP: begin
                            request                   = DriveMax;
                            state_base.hold_direction = DirUp;
                        end
                        MODE_DOWN: begin
                            request                   = DriveMin;
                            state_base.hold_direction = DirDown;
                        end
                        MODE_HOLD: request = hold_drive;
                        MODE_POS:  request = clamp_drive(pos_diff);
                        // Velocity stop and unreachable codes skip the stall check.
                        default:   use_drive = 1'b0;
                    endcase
                end
            end
        endcase
    end

    // Stall check on the clamped request.
    assign magnitude = request[7] ? 8'(-request) : 8'(request);
    assign stalled   = (item.current_ma >= cfg.current_limit)
                     && (magnitude > {2'b00, cfg.hold_value, 1'b0});
    assign count_inc = (state.stall_count == StallCountMax) ? StallCountMax
                     : state.stall_count + 8'd1;
    assign safe_new  = state.safe_flag || (count_inc > StallSteps);

    always_comb begin
        result.drive         = 8'sd0;
        result.velocity_stop = 1'b0;
        result.safe_mode     = state.safe_flag;
        if (use_drive) begin
            if (stalled) begin
                result.safe_mode = safe_new;
                // The forced drive uses the direction held before this step.
                result.drive     = safe_new ? hold_drive : request;
            end else begin
                result.safe_mode = 1'b0;
                result.drive     = request;
            end
        end else begin
            result.velocity_stop = 1'b1;
        end
    end

    // The stall state only moves when a drive value is applied.
    logic [7:0] count_sel;
    logic       safe_sel;
    assign count_sel = stalled ? count_inc : 8'd0;
    assign safe_sel  = stalled ? safe_new : 1'b0;

    always_comb begin
        state_next = state_base;
        if (use_drive) begin
            state_next.stall_count = count_sel;
            state_next.safe_flag   = safe_sel;
        end
    end

endmodule

/* rtl/motor_drive_stall_guard.sv */
// ============================================================================
// motor_drive_stall_guard
// Open-loop motor drive with stall protection and hold modes.
// ============================================================================
// Commands enter on the s_ channel (valid/ready). A control tick or a direct
// drive request produces one transaction on the m_ channel; a mode write or a
// target write updates the drive state and produces none.
// Configuration registers (hold value, current limit) are written through
// cfg_we/cfg_addr/cfg_wdata, one write per cycle. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A command is captured in the input register; the drive and stall check
// are then computed from it, the result is written to the output register,
// where it appears on m_data, and the state update to the state register.
// Throughput is one command per cycle while the receiver keeps up; the state
// update is completed in the same step that processes a command, so
// consecutive commands never wait on each other's state.
// When the receiver stalls, the result holds in the output register and the
// input register keeps one more command; s_ready drops only when both are
// full. Reset clears the stall counter, safe flag, hold direction, target
// position and mode (hold), and sets the configuration to its defaults.
// ============================================================================
module motor_drive_stall_guard
    import mdsg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_item_t                s_data,

    output logic                    m_valid,
    input  logic                    m_ready,
    output out_item_t               m_data,

    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [CfgDataWidth-1:0] cfg_wdata
);

    logic         in_vld_reg, in_vld_next;
    in_item_t     in_item_reg;
    logic         m_vld_reg, m_vld_next;
    out_item_t    m_data_reg;
    guard_state_t state_reg;
    guard_state_t state_next;
    guard_cfg_t   cfg_reg;

    logic         has_result;
    out_item_t    result;
    logic         out_free;
    logic         advance;

    mdsg_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .result     (result),
        .state_next (state_next)
    );

    assign out_free = !m_vld_reg || m_ready;
    assign advance  = in_vld_reg && (!has_result || out_free);
    assign s_ready  = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        m_vld_next = m_vld_reg;
        if (advance && has_result) begin
            m_vld_next = 1'b1;
        end else if (m_ready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg                <= 1'b0;
            m_vld_reg                 <= 1'b0;
            state_reg.stall_count     <= 8'd0;
            state_reg.safe_flag       <= 1'b0;
            state_reg.hold_direction  <= DirNone;
            state_reg.mode_code       <= MODE_HOLD;
            state_reg.target_position <= 32'sd0;
            cfg_reg.hold_value        <= HoldValueReset;
            cfg_reg.current_limit     <= CurrentLimitReset;
        end else begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_HOLD_VALUE:    cfg_reg.hold_value    <= cfg_wdata[4:0];
                    CFG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_wdata;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance && has_result) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    // Safe mode can only be on after more than the allowed stalled steps.
    a_safe_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.safe_flag |-> (state_reg.stall_count > StallSteps))
        else $error("safe flag set with a short stall count");

    // The hold direction is only ever -1, 0 or +1.
    a_dir_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hold_direction != 2'sb10)
        else $error("illegal hold direction");

    // A velocity stop result always carries a zero drive.
    a_vstop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.velocity_stop) |-> (m_data.drive == 8'sd0))
        else $error("velocity stop with nonzero drive");

    // The drive never leaves the symmetric range.
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.drive != 8'sh80))
        else $error("drive out of range");

    // A full input register that cannot move is what blocks the input.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && has_result && m_vld_reg && !m_ready))
        else $error("input blocked without a stalled result");

endmodule

/* verif/motor_drive_stall_guard_tb.sv */
// ============================================================================
// motor_drive_stall_guard_tb
// Self-checking testbench for the motor drive stall guard.
// ============================================================================
// A predictor inside a small scoreboard class keeps its own copy of the drive
// state and the two registers. It works out the expected drive transaction
// for every accepted command, and each transaction on the m_ channel is
// checked field by field against the oldest one waiting. The stimulus is a
// short directed part followed by phases at several register settings. Those
// phases mix random commands with long runs of high current and large drive,
// so that the stall counter fills, safe mode engages and the counter
// saturates. Both channels pause in random bursts.
// ============================================================================
module motor_drive_stall_guard_tb;
    import mdsg_pkg::*;

    class drive_predictor;
        logic [4:0]         hold_value;
        logic [11:0]        current_limit;
        logic [7:0]         stall_count;
        logic               safe_flag;
        logic signed [1:0]  hold_direction;
        mode_t              mode_code;
        logic signed [31:0] target_position;
        out_item_t          expected_drives[$];
        int                 errors;
        int                 checked;
        int                 safe_seen;
        int                 vstop_seen;

        function new();
            hold_value      = HoldValueReset;
            current_limit   = CurrentLimitReset;
            stall_count     = '0;
            safe_flag       = 1'b0;
            hold_direction  = DirNone;
            mode_code       = MODE_HOLD;
            target_position = '0;
            errors          = 0;
            checked         = 0;
            safe_seen       = 0;
            vstop_seen      = 0;
        endfunction

        function void configure(logic [4:0] hv, logic [11:0] lim);
            hold_value    = hv;
            current_limit = lim;
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Clamp a drive request, run the stall check and apply safe mode.
        function logic signed [7:0] guarded_drive(longint request, logic [11:0] current);
            longint clamped;
            longint mag;
            clamped = request;
            if (clamped > longint'(DriveMax)) clamped = longint'(DriveMax);
            if (clamped < longint'(DriveMin)) clamped = longint'(DriveMin);
            mag = (clamped < 0) ? -clamped : clamped;
            if (current >= current_limit && mag > 2 * longint'(hold_value)) begin
                if (stall_count < StallCountMax) stall_count++;
                if (stall_count > StallSteps) safe_flag = 1'b1;
            end else begin
                stall_count = '0;
                safe_flag   = 1'b0;
            end
            // The forced drive uses the direction held before this step.
            if (safe_flag) clamped = longint'(hold_value) * longint'(hold_direction);
            return clamped[7:0];
        endfunction

        function void note_command(in_item_t item);
            out_item_t res;
            res = '0;
            case (cmd_t'(item.cmd))
                CMD_MODE: begin
                    if (item.value == 1) mode_code = MODE_UP;
                    else if (item.value == -1) mode_code = MODE_DOWN;
                    else if (item.value == 0) mode_code = MODE_HOLD;
                    else if (item.value == 2) mode_code = MODE_POS;
                    else mode_code = MODE_VSTOP;
                    return;
                end
                CMD_TARGET: begin
                    mode_code       = MODE_POS;
                    target_position = item.value;
                    return;
                end
                CMD_DRIVE: begin
                    res.drive = guarded_drive(longint'(item.value), item.current_ma);
                end
                default: begin
                    if (item.button_up) begin
                        res.drive      = guarded_drive(longint'(DriveMax), item.current_ma);
                        mode_code      = MODE_HOLD;
                        hold_direction = DirUp;
                    end else if (item.button_down) begin
                        res.drive      = guarded_drive(longint'(DriveMin), item.current_ma);
                        mode_code      = MODE_HOLD;
                        hold_direction = DirDown;
                    end else begin
                        case (mode_code)
                            MODE_UP: begin
                                res.drive = guarded_drive(longint'(DriveMax), item.current_ma);
                                hold_direction = DirUp;
                            end
                            MODE_DOWN: begin
                                res.drive = guarded_drive(longint'(DriveMin), item.current_ma);
                                hold_direction = DirDown;
                            end
                            MODE_HOLD: begin
                                res.drive = guarded_drive(longint'(hold_value) *
                                    longint'(hold_direction), item.current_ma);
                            end
                            MODE_POS: begin
                                res.drive = guarded_drive(longint'(target_position) -
                                    longint'(item.position), item.current_ma);
                            end
                            default: begin
                                // Velocity stop leaves the stall counter alone.
                                res.drive         = '0;
                                res.velocity_stop = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
            res.safe_mode = safe_flag;
            expected_drives = {expected_drives, res};
        endfunction

        task check_drive(out_item_t got);
            out_item_t want;
            if (expected_drives.size() == 0) begin
                report("drive transaction with no command waiting");
                return;
            end
            want = expected_drives.pop_front();
            checked++;
            if (want.safe_mode) safe_seen++;
            if (want.velocity_stop) vstop_seen++;
            if (got.drive !== want.drive)
                report($sformatf("drive %0d, expected %0d", got.drive, want.drive));
            if (got.velocity_stop !== want.velocity_stop)
                report($sformatf("velocity_stop %b, expected %b",
                                 got.velocity_stop, want.velocity_stop));
            if (got.safe_mode !== want.safe_mode)
                report($sformatf("safe_mode %b, expected %b", got.safe_mode, want.safe_mode));
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    in_item_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    out_item_t               m_data;
    logic                    cfg_we;
    logic                    cfg_addr;
    logic [CfgDataWidth-1:0] cfg_wdata;

    drive_predictor guard = new();
    bit             idling = 1'b0;
    int             commands_sent = 0;

    motor_drive_stall_guard u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) guard.check_drive(m_data);
    end

    initial begin : result_side
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (idling && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : run_limit
        #5000000;
        $display("simulation failed");
        $finish;
    end

    function automatic in_item_t make_item(cmd_t c, logic up, logic dn,
                                           logic signed [31:0] v, logic [11:0] cur,
                                           logic signed [31:0] pos);
        in_item_t item;
        item.cmd         = c;
        item.button_up   = up;
        item.button_down = dn;
        item.value       = v;
        item.current_ma  = cur;
        item.position    = pos;
        return item;
    endfunction

    function automatic in_item_t random_command();
        in_item_t item;
        item.cmd         = 2'($urandom_range(0, 3));
        item.button_up   = ($urandom_range(0, 2) == 0);
        item.button_down = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 4))
            0: item.value = $urandom;
            1: item.value = int'($urandom_range(0, 6)) - 3;
            2: item.value = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(100, 300));
            3: item.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: item.value = int'($urandom_range(0, 3)) - 128 +
                                  ($urandom_range(0, 1) ? 0 : 254);
        endcase
        if ($urandom_range(0, 1)) item.current_ma = 12'($urandom);
        else item.current_ma = 12'($urandom_range(guard.current_limit, 12'hFFF));
        if ($urandom_range(0, 1)) item.position = $urandom;
        else item.position = int'($urandom_range(0, 400)) - 200;
        return item;
    endfunction

    task automatic send_command(input in_item_t item);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        guard.note_command(item);
        commands_sent++;
    endtask

    // Waits until every expected drive transaction has arrived, then lets a
    // trailing mode or target write work through the pipeline.
    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (guard.pending() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [4:0] hv, input logic [11:0] lim);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_HOLD_VALUE;
        cfg_wdata <= {7'd0, hv};
        @(posedge aclk);
        cfg_addr  <= CFG_CURRENT_LIMIT;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        guard.configure(hv, lim);
    endtask

    // A run of drive steps at or above the current limit with a drive large
    // enough to count as stalled. Mode writes and velocity stop ticks are
    // mixed in, since neither of them clears the stall counter.
    task automatic stall_run(input int steps);
        int                 source;
        logic signed [31:0] mode_value;
        logic signed [31:0] target;
        logic signed [31:0] request;
        logic signed [31:0] offset;
        logic [11:0]        cur;
        source = $urandom_range(0, 3);
        target = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
        case (source)
            0: mode_value = 1;
            1: mode_value = -1;
            2: mode_value = 0;
            default: mode_value = 2;
        endcase
        if (source == 3) send_command(make_item(CMD_TARGET, 1'b0, 1'b0, target, 12'd0, 0));
        else send_command(make_item(CMD_MODE, 1'b0, 1'b0, mode_value, 12'd0, 0));
        for (int i = 0; i < steps; i++) begin
            cur = 12'($urandom_range(guard.current_limit, 12'hFFF));
            if ($urandom_range(0, 11) == 0) begin
                send_command(make_item(CMD_MODE, 1'b0, 1'b0, 5, cur, $urandom));
                send_command(make_item(CMD_TICK, 1'b0, 1'b0, $urandom, cur, $urandom));
                send_command(make_item(CMD_MODE, 1'b0, 1'b0, mode_value, cur, $urandom));
            end
            if (source == 2) begin
                request = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(64, 2000000));
                if ($urandom_range(0, 9) == 0)
                    request = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                send_command(make_item(CMD_DRIVE, 1'b0, 1'b0, request, cur, $urandom));
            end else begin
                offset = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(100, 1 << 20));
                send_command(make_item(CMD_TICK, 1'b0, 1'b0, $urandom, cur, target + offset));
            end
        end
    endtask

    task automatic directed_part();
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b1, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b1, 0, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b1, 1'b1, 0, 12'd0, 0));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 1, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, -1, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 0));
        // Position hold with differences that only fit at full width.
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 2, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 32'sh7FFF_FFFF));
        send_command(make_item(CMD_TARGET, 1'b0, 1'b0, 32'sh7FFF_FFFF, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'd0, 32'sh8000_0000));
        send_command(make_item(CMD_TARGET, 1'b0, 1'b0, -200, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'hFFF, -150));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 5, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b0, 1'b0, 0, 12'hFFF, 0));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 32'sh8000_0000, 12'd0, 0));
        send_command(make_item(CMD_TICK,   1'b1, 1'b0, 0, 12'd0, 0));
        send_command(make_item(CMD_MODE,   1'b0, 1'b0, 32'sh7FFF_FFFF, 12'd0, 0));
        send_command(make_item(CMD_DRIVE,  1'b0, 1'b0, 32'sh8000_0000, 12'hFFF, 0));
        send_command(make_item(CMD_DRIVE,  1'b0, 1'b0, 32'sh7FFF_FFFF, 12'hFFF, 0));
        send_command(make_item(CMD_DRIVE,  1'b0, 1'b0, 0, 12'hFFF, 0));
    endtask

    initial begin : stimulus
        logic [4:0]  hold_list[8];
        logic [11:0] limit_list[8];
        int          phase_end;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_HOLD_VALUE;
        cfg_wdata <= '0;
        hold_list  = '{5'd20, 5'd0, 5'd31, 5'd10, 5'd0, 5'd1, 5'd0, 5'd20};
        limit_list = '{12'd2300, 12'd0, 12'hFFF, 12'd1000, 12'd0, 12'hFFF, 12'd0, 12'd0};
        hold_list[4]  = 5'($urandom);
        limit_list[4] = 12'($urandom);
        hold_list[6]  = 5'($urandom);
        limit_list[6] = 12'($urandom_range(0, 2300));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_part();

        for (int p = 0; p < 8; p++) begin
            drain();
            apply_settings(hold_list[p], limit_list[p]);
            // The last phase runs without pauses on either side.
            idling = (p != 7) && ($urandom_range(0, 3) != 0);
            if (p == 3) begin
                // Long enough for the stall counter to saturate.
                stall_run(262);
            end else begin
                phase_end = commands_sent + 10;
                while (commands_sent < phase_end) begin
                    if ($urandom_range(0, 2) == 0) stall_run($urandom_range(32, 45));
                    else repeat ($urandom_range(1, 8)) send_command(random_command());
                end
            end
        end

        drain();
        if (guard.pending() != 0)
            guard.report($sformatf("%0d drive transactions never arrived", guard.pending()));
        $display("Sent %0d commands over 8 register settings; checked %0d drive transactions,",
                 commands_sent, guard.checked);
        $display("of which %0d in safe mode and %0d with velocity stop.",
                 guard.safe_seen, guard.vstop_seen);
        if (guard.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
